// ----- design/rpe_pkg.sv -----
// ----------------------------------------------------------------------------
// rpe_pkg
// Shared constants, types and GF(2^8) arithmetic for the parity encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rpe_pkg;

  localparam int MaxData   = 16;
  localparam int MaxParity = 8;

  localparam int ByteW        = 8;
  localparam int DataCountW   = 5;
  localparam int ParityCountW = 4;
  localparam int UnitCountW   = 4;
  localparam int IndexW       = 3;
  localparam int LeftW        = 4;

  localparam logic [8:0] GfPoly = 9'h11d;

  localparam logic [DataCountW-1:0]   DataCountReset   = 5'd6;
  localparam logic [ParityCountW-1:0] ParityCountReset = 4'd3;

  // Register indexes on the configuration port.
  localparam logic RegDataCount   = 1'b0;
  localparam logic RegParityCount = 1'b1;

  typedef logic [ByteW-1:0] byte_t;
  typedef byte_t [MaxParity-1:0] row_bytes_t;

  typedef struct packed {
    logic       valid;
    row_bytes_t acc;
  } column_t;

  function automatic byte_t gf_mul(input byte_t a, input byte_t b);
    logic [8:0] x;
    byte_t      r;
    x = {1'b0, a};
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        r = r ^ x[7:0];
      end
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ GfPoly;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/rpe_cfg.sv -----
// ----------------------------------------------------------------------------
// rpe_cfg
// Configuration registers behind the APB-style port, with count clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module rpe_cfg
  import rpe_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [2:0]              paddr,
  input  wire logic [31:0]             pwdata,
  output logic      [31:0]             prdata,
  output logic                         pready,
  output logic [DataCountW-1:0]        data_count,
  output logic [ParityCountW-1:0]      parity_count,
  output logic                         restart
);

  logic                    wr_en;
  logic [DataCountW-1:0]   dc_in;
  logic [ParityCountW-1:0] pc_in;
  logic [DataCountW-1:0]   dc_next;
  logic [ParityCountW-1:0] pc_next;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign dc_in  = pwdata[DataCountW-1:0];
  assign pc_in  = pwdata[ParityCountW-1:0];

  always_comb begin
    if (dc_in == '0) begin
      dc_next = DataCountW'(1);
    end else if (dc_in > DataCountW'(MaxData)) begin
      dc_next = DataCountW'(MaxData);
    end else begin
      dc_next = dc_in;
    end
    if (pc_in == '0) begin
      pc_next = ParityCountW'(1);
    end else if (pc_in > ParityCountW'(MaxParity)) begin
      pc_next = ParityCountW'(MaxParity);
    end else begin
      pc_next = pc_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_count   <= DataCountReset;
      parity_count <= ParityCountReset;
    end else if (wr_en) begin
      if (paddr[2] == RegDataCount) begin
        data_count <= dc_next;
      end else begin
        parity_count <= pc_next;
      end
    end
  end

  assign restart = wr_en;

  always_comb begin
    if (paddr[2] == RegParityCount) begin
      prdata = {{(32-ParityCountW){1'b0}}, parity_count};
    end else begin
      prdata = {{(32-DataCountW){1'b0}}, data_count};
    end
  end

  logic unused_bits;
  assign unused_bits = ^{paddr[1:0], pwdata[31:DataCountW]};

endmodule

`default_nettype wire

// ----- design/rpe_accum.sv -----
// ----------------------------------------------------------------------------
// rpe_accum
// Input register and per-row parity accumulators with running coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module rpe_accum
  import rpe_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    restart,
  input  wire logic [DataCountW-1:0]   data_count,
  input  wire logic [ParityCountW-1:0] parity_count,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire byte_t                   in_byte,
  output column_t                      column,
  input  wire logic                    column_ready
);

  logic                  s1_valid;
  byte_t                 s1_byte;
  logic [UnitCountW-1:0] unit_count;
  row_bytes_t            acc;
  row_bytes_t            power;
  row_bytes_t            acc_next;
  row_bytes_t            power_next;
  logic                  s1_last;
  logic                  s1_fire;

  assign s1_last  = ({1'b0, unit_count} + DataCountW'(1)) >= data_count;
  assign s1_fire  = s1_valid && (!s1_last || column_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_comb begin
    for (int p = 0; p < MaxParity; p++) begin
      if (p < int'(parity_count)) begin
        acc_next[p]   = acc[p] ^ gf_mul(power[p], s1_byte);
        power_next[p] = gf_mul(power[p], ByteW'(p + 1));
      end else begin
        acc_next[p]   = acc[p];
        power_next[p] = power[p];
      end
    end
  end

  assign column.valid = s1_valid && s1_last;
  assign column.acc   = acc_next;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      s1_valid   <= 1'b0;
      unit_count <= '0;
      for (int p = 0; p < MaxParity; p++) begin
        acc[p]   <= '0;
        power[p] <= ByteW'(1);
      end
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_fire) begin
        if (s1_last) begin
          unit_count <= '0;
          for (int p = 0; p < MaxParity; p++) begin
            acc[p]   <= '0;
            power[p] <= ByteW'(1);
          end
        end else begin
          unit_count <= unit_count + UnitCountW'(1);
          acc        <= acc_next;
          power      <= power_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= in_byte;
    end
  end

endmodule

`default_nettype wire

// ----- design/rpe_emit.sv -----
// ----------------------------------------------------------------------------
// rpe_emit
// Holds a column's finished parity bytes; sends one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module rpe_emit
  import rpe_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [ParityCountW-1:0] parity_count,
  input  wire column_t                 column,
  output logic                         column_ready,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output byte_t                        out_byte,
  output logic [IndexW-1:0]            out_index,
  output logic                         out_last
);

  row_bytes_t          held;
  logic [LeftW-1:0]    left;
  logic [IndexW-1:0]   idx;
  logic                move;

  assign column_ready = (left == '0);
  assign move         = (left != '0) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      left      <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (column.valid && column_ready) begin
        left <= LeftW'(parity_count);
        idx  <= '0;
      end else if (move) begin
        left <= left - LeftW'(1);
        idx  <= idx + IndexW'(1);
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (column.valid && column_ready) begin
      held <= column.acc;
    end
    if (move) begin
      out_byte  <= held[idx];
      out_index <= idx;
      out_last  <= (left == LeftW'(1));
    end
  end

endmodule

`default_nettype wire

// ----- design/rs_parity_encoder_gf256_top.sv -----
// ----------------------------------------------------------------------------
// rs_parity_encoder_gf256_top
// Reed-Solomon erasure parity encoder over GF(2^8), polynomial 0x11d.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_*       in         data_byte, one per data unit of a column
// m_*       out        parity_byte, parity_index, last_parity (tlast)
// APB       in/out     data_count at 0x0, parity_count at 0x4
//
// A data byte is taken every cycle while s_tready is high; it passes an input
// register and then updates the parity rows below parity_count. After the
// last byte of a column the parity bytes leave at one per cycle from a
// holding buffer while m_tready is high. The last byte of the next column
// waits in the input register until the buffer has been emptied.
// Reset is synchronous; any register write restarts the column.
// ----------------------------------------------------------------------------
`default_nettype none

module rs_parity_encoder_gf256_top
  import rpe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] parity_byte, [10:8] parity_index
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [DataCountW-1:0]   data_count;
  logic [ParityCountW-1:0] parity_count;
  logic                    restart;
  column_t                 column;
  logic                    column_ready;
  byte_t                   out_byte;
  logic [IndexW-1:0]       out_index;

  rpe_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .data_count   (data_count),
    .parity_count (parity_count),
    .restart      (restart)
  );

  rpe_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .restart      (restart),
    .data_count   (data_count),
    .parity_count (parity_count),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_byte      (s_tdata),
    .column       (column),
    .column_ready (column_ready)
  );

  rpe_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .parity_count (parity_count),
    .column       (column),
    .column_ready (column_ready),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_byte     (out_byte),
    .out_index    (out_index),
    .out_last     (m_tlast)
  );

  assign m_tdata = {5'b0, out_index, out_byte};

endmodule

`default_nettype wire

// ----- tb/sv/rs_parity_encoder_gf256_top_test.sv -----
// ----------------------------------------------------------------------------
// rs_parity_encoder_gf256_top_test
// Stream-level test of the GF(2^8) erasure parity encoder: a clocked driver
// sends data bytes from a queue, a clocked monitor checks every parity item
// against a predictor of the column accumulators, and register writes on the
// APB port switch the data and parity counts between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rs_parity_encoder_gf256_top_test;
  import rpe_pkg::*;

  typedef struct packed {
    logic [7:0] parity;
    logic [2:0] index;
    logic       last;
  } parity_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  wire  [15:0] m_tdata;           // [7:0] parity_byte, [10:8] parity_index
  wire         m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  wire  [31:0] prdata;
  wire         pready;

  logic [7:0]   data_bytes_pending[$];
  parity_item_t parity_expected[$];
  logic [7:0]   column_acc[MaxParity];
  logic [7:0]   column_coef[MaxParity];
  int           units_taken;
  int           data_len = 6;
  int           parity_len = 3;
  int           sender_idle_pct = 13;
  int           receiver_idle_pct = 76;
  int           error_count = 0;

  rs_parity_encoder_gf256_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] sum;
    logic [7:0] term;
    sum = 8'h00;
    term = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        sum = sum ^ term;
      end
      term = {term[6:0], 1'b0} ^ (term[7] ? 8'h1d : 8'h00);
    end
    return sum;
  endfunction

  function automatic int clamp_count(input int raw, input int limit);
    if (raw == 0) begin
      return 1;
    end
    if (raw > limit) begin
      return limit;
    end
    return raw;
  endfunction

  task automatic clear_column();
    for (int p = 0; p < MaxParity; p++) begin
      column_acc[p] = 8'h00;
      column_coef[p] = 8'h01;
    end
    units_taken = 0;
  endtask

  task automatic encode_data_byte(input logic [7:0] value);
    parity_item_t item;
    for (int p = 0; p < parity_len; p++) begin
      column_acc[p] = column_acc[p] ^ gf_product(column_coef[p], value);
      column_coef[p] = gf_product(column_coef[p], 8'(p + 1));
    end
    if (units_taken + 1 < data_len) begin
      units_taken++;
    end else begin
      for (int p = 0; p < parity_len; p++) begin
        item.parity = column_acc[p];
        item.index = 3'(p);
        item.last = (p + 1 == parity_len);
        parity_expected = {parity_expected, item};
      end
      clear_column();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        encode_data_byte(s_tdata);
      end
      if (!s_tvalid || s_tready) begin
        if (data_bytes_pending.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= data_bytes_pending.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (parity_expected.size() == 0) begin
          $display("%0t: unexpected parity item, expected none, actual byte=%02h index=%0d last=%0b",
                   $time, m_tdata[7:0], m_tdata[10:8], m_tlast);
          error_count++;
        end else begin
          automatic parity_item_t want = parity_expected.pop_front();
          if (m_tdata[7:0] !== want.parity) begin
            $display("%0t: parity_byte mismatch, expected %02h actual %02h",
                     $time, want.parity, m_tdata[7:0]);
            error_count++;
          end
          if (m_tdata[10:8] !== want.index) begin
            $display("%0t: parity_index mismatch, expected %0d actual %0d",
                     $time, want.index, m_tdata[10:8]);
            error_count++;
          end
          if (m_tlast !== want.last) begin
            $display("%0t: last_parity mismatch, expected %0b actual %0b",
                     $time, want.last, m_tlast);
            error_count++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  task automatic apb_write(input logic reg_idx, input int raw);
    logic [31:0] value;
    value = $urandom();
    if (reg_idx == RegDataCount) begin
      value[4:0] = raw[4:0];
    end else begin
      value[3:0] = raw[3:0];
    end
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == RegDataCount) begin
      data_len = clamp_count(value[4:0], MaxData);
    end else begin
      parity_len = clamp_count(value[3:0], MaxParity);
    end
    clear_column();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(input int raw_data, input int raw_parity);
    apb_write(RegDataCount, raw_data);
    apb_write(RegParityCount, raw_parity);
    @(negedge clk);
  endtask

  task automatic push_random(input int count);
    for (int i = 0; i < count; i++) begin
      data_bytes_pending = {data_bytes_pending, 8'($urandom_range(0, 255))};
    end
  endtask

  // The block may still be folding accepted bytes into a column that has no
  // result yet, so a quiet stretch follows before anything else happens.
  task automatic wait_idle();
    do @(negedge clk);
    while (data_bytes_pending.size() != 0 || s_tvalid || parity_expected.size() != 0);
    repeat (32) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_random_phase(input int items);
    int pushed;
    int count;
    int raw_data;
    int raw_parity;
    pushed = 0;
    while (pushed < items) begin
      raw_data = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
      raw_parity = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      configure(raw_data, raw_parity);
      count = $urandom_range(1, 4) * data_len;
      if ($urandom_range(0, 3) == 0 && data_len > 1) begin
        count += $urandom_range(1, data_len - 1);
      end
      push_random(count);
      pushed += count;
      wait_idle();
    end
  endtask

  initial begin
    clear_column();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Default counts, then a partial column that a register write discards.
    data_bytes_pending = '{8'h00, 8'hff, 8'h01, 8'h80, 8'haa, 8'h55};
    wait_idle();
    data_bytes_pending = '{8'h3c, 8'hc3};
    wait_idle();
    configure(1, 8);
    data_bytes_pending = '{8'hff, 8'h00};
    wait_idle();
    // Zero counts act as one, oversized counts saturate.
    configure(0, 0);
    data_bytes_pending = {data_bytes_pending, 8'h5a};
    wait_idle();
    configure(31, 15);
    push_random(16);
    wait_idle();

    run_random_phase(140);
    sender_idle_pct = 76;
    receiver_idle_pct = 13;
    run_random_phase(140);
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    run_random_phase(140);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
